// File: src/rbps_pkg.sv
// shared types and constants for the ray box pick selector
`timescale 1ns / 1ps
package rbps_pkg;
    localparam int COORD_W = 32;
    localparam int DIR_W   = 18;
    localparam int RCP_W   = 33;
    localparam int T_W     = 64;
    localparam int VOL_W   = 64;
    localparam logic [T_W-1:0] T_FAR = {1'b0, {(T_W-1){1'b1}}};

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_PREFER   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_AX0, ST_AX1, ST_AX2, ST_VOL1, ST_VOL2, ST_VOL3, ST_PUSH
    } front_state_t;

    typedef struct packed {
        logic              hit;
        logic [T_W-1:0]    tmin;
        logic [VOL_W-1:0]  vol;
        logic [31:0]       id;
        logic              last;
        logic              prefer;
    } box_result_t;
endpackage

// File: src/ray_box_pick_selector.sv
// top level of the ray box pick selector
// per box: accept, three slab steps, three volume steps, push; the push waits for room
// in the back queue, and no new box is taken until that push is done
// after a direction write the reciprocal unit reruns all three axes in turn
// before boxes are taken
// reset: asynchronous active low; scan state cleared, registers to defaults, then the same
// reciprocal pass over all three axes
`timescale 1ns / 1ps
module ray_box_pick_selector
    import rbps_pkg::*;
#(
    parameter int ID_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [207:0] s_axis_tdata,  // box_min_x,y,z, box_max_x,y,z, object_id
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,  // hit_found, hit_object
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [DIR_W-1:0]   dir_reg [3];
    logic                      prefer_reg;
    logic [RCP_W-1:0] rmag_reg [3];
    logic             rneg_reg [3];
    logic [1:0]       rax_reg;
    logic             rbusy_reg, rstart_reg;
    logic             rdone;
    logic [RCP_W-1:0] rmag;
    logic             rneg;
    logic             f_ready, f_valid, b_ready;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    box_result_t      fr;
    logic             hf;
    logic [15:0]      ho;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0; org_reg[1] <= '0; org_reg[2] <= '0;
            dir_reg[0] <= '0; dir_reg[1] <= -18'sd65536; dir_reg[2] <= '0;
            prefer_reg <= 1'b0;
            rbusy_reg  <= 1'b1;
            rstart_reg <= 1'b1;
            rax_reg    <= 2'd0;
        end
        else
        begin
            rstart_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                    REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                    REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                    REG_DIR_X:    dir_reg[0] <= cfg_wdata[DIR_W-1:0];
                    REG_DIR_Y:    dir_reg[1] <= cfg_wdata[DIR_W-1:0];
                    REG_DIR_Z:    dir_reg[2] <= cfg_wdata[DIR_W-1:0];
                    REG_PREFER:   prefer_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            // any direction write reruns all three reciprocals
            if (cfg_we && (cfg_index == REG_DIR_X || cfg_index == REG_DIR_Y
                           || cfg_index == REG_DIR_Z))
            begin
                rbusy_reg  <= 1'b1;
                rstart_reg <= 1'b1;
                rax_reg    <= 2'd0;
            end
            // a done from an abandoned run is dropped while a restart is pending
            else if (rdone && !rstart_reg)
            begin
                if (rax_reg == 2'd2) rbusy_reg <= 1'b0;
                else
                begin
                    rax_reg    <= rax_reg + 2'd1;
                    rstart_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdone && !rstart_reg)
        begin
            rmag_reg[rax_reg] <= rmag;
            rneg_reg[rax_reg] <= rneg;
        end
    end

    rbps_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rstart_reg && !(cfg_we && (cfg_index == REG_DIR_X
                 || cfg_index == REG_DIR_Y || cfg_index == REG_DIR_Z))),
        .dir   (dir_reg[rax_reg]),
        .done  (rdone),
        .mag   (rmag),
        .neg   (rneg)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = s_axis_tdata[32*i +: 32];
            hi[i] = s_axis_tdata[96 + 32*i +: 32];
        end
    end

    rbps_front #(.ID_BITS(ID_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid && !rbusy_reg),
        .in_ready  (f_ready),
        .box_lo    (lo),
        .box_hi    (hi),
        .id_in     (s_axis_tdata[207:192]),
        .last_in   (s_axis_tlast),
        .origin    (org_reg),
        .rcp_mag   (rmag_reg),
        .rcp_neg   (rneg_reg),
        .prefer    (prefer_reg),
        .out_valid (f_valid),
        .out_ready (b_ready),
        .out_data  (fr)
    );

    assign s_axis_tready = f_ready && !rbusy_reg;

    rbps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (b_ready),
        .in_data    (fr),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hit_found  (hf),
        .hit_object (ho)
    );

    assign m_axis_tdata = {7'd0, ho, hf};
endmodule

// File: src/rbps_recip.sv
// iterative reciprocal 2^32 / |d| for one direction component
`timescale 1ns / 1ps
module rbps_recip
    import rbps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIR_W-1:0] dir,
    output logic                    done,
    output logic [RCP_W-1:0]        mag,
    output logic                    neg
);
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [RCP_W:0]   rem_reg, rem_next;
    logic [RCP_W-1:0] quo_reg, quo_next;
    logic [DIR_W-1:0] div_reg, div_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic [RCP_W:0]   trial;
    logic             num_bit;

    // restoring division of 2^32 one bit a cycle, msb first
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        num_bit   = (cnt_reg == 6'd32);
        trial     = {rem_reg[RCP_W-1:0], num_bit};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = '0;
            quo_next  = '0;
            div_next  = dir[DIR_W-1] ? DIR_W'(-dir) : dir;
            neg_next  = dir[DIR_W-1];
        end
        else if (busy_reg)
        begin
            if (div_reg == '0)
            begin
                quo_next  = {1'b1, {(RCP_W-1){1'b0}}};
                neg_next  = 1'b0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (trial >= {{(RCP_W+1-DIR_W){1'b0}}, div_reg})
                begin
                    rem_next = trial - {{(RCP_W+1-DIR_W){1'b0}}, div_reg};
                    quo_next = {quo_reg[RCP_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[RCP_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign mag  = quo_reg;
    assign neg  = neg_reg;
endmodule

// File: src/rbps_front.sv
// front: slab test and volume per box, one axis at a time
`timescale 1ns / 1ps
module rbps_front
    import rbps_pkg::*;
#(
    parameter int ID_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] box_lo [3],
    input  logic signed [COORD_W-1:0] box_hi [3],
    input  logic [15:0]               id_in,
    input  logic                      last_in,
    input  logic signed [COORD_W-1:0] origin [3],
    input  logic [RCP_W-1:0]          rcp_mag [3],
    input  logic                      rcp_neg [3],
    input  logic                      prefer,
    output logic                      out_valid,
    input  logic                      out_ready,
    output box_result_t               out_data
);
    front_state_t st_reg, st_next;
    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];
    logic [15:0]      id_reg;
    logic             last_reg;
    logic signed [T_W-1:0] tmin_reg, tmin_next, tmax_reg, tmax_next;
    logic [VOL_W-1:0] vol_reg, vol_next;
    logic [VOL_W-1:0] part_reg, part_next;
    logic [32:0]      ext_reg [3];
    logic [1:0]       ax;
    logic signed [COORD_W:0] d0, d1;
    logic [COORD_W:0] m0, m1;
    logic [65:0]      p0, p1;
    logic [T_W-1:0]   s0, s1;
    logic signed [T_W-1:0] t0, t1, ta, tb;
    logic [31:0]      mul_a;
    logic [63:0]      vp;
    logic [64:0]      vsum;
    logic [32:0]      vext;

    always_comb
    begin
        unique case (st_reg)
            ST_AX1:  ax = 2'd1;
            ST_AX2:  ax = 2'd2;
            default: ax = 2'd0;
        endcase
    end

    // one axis of the slab test: two 33x33 products, saturated and signed
    always_comb
    begin
        d0 = {lo_reg[ax][COORD_W-1], lo_reg[ax]} - {origin[ax][COORD_W-1], origin[ax]};
        d1 = {hi_reg[ax][COORD_W-1], hi_reg[ax]} - {origin[ax][COORD_W-1], origin[ax]};
        m0 = d0[COORD_W] ? (COORD_W+1)'(-d0) : d0;
        m1 = d1[COORD_W] ? (COORD_W+1)'(-d1) : d1;
        p0 = m0 * rcp_mag[ax];
        p1 = m1 * rcp_mag[ax];
        s0 = (p0 > 66'(T_FAR)) ? T_FAR : p0[T_W-1:0];
        s1 = (p1 > 66'(T_FAR)) ? T_FAR : p1[T_W-1:0];
        t0 = (d0[COORD_W] != rcp_neg[ax]) ? -$signed(s0) : $signed(s0);
        t1 = (d1[COORD_W] != rcp_neg[ax]) ? -$signed(s1) : $signed(s1);
        ta = rcp_neg[ax] ? t1 : t0;
        tb = rcp_neg[ax] ? t0 : t1;
    end

    // volume: one 32x32 product a cycle, the product so far taken in two halves for the last extent
    always_comb
    begin
        vext  = (st_reg == ST_VOL1) ? ext_reg[1] : ext_reg[2];
        mul_a = (st_reg == ST_VOL3) ? vol_reg[63:32] : vol_reg[31:0];
        vp    = {32'd0, mul_a} * {32'd0, vext[31:0]};
        vsum  = {1'b0, vp[31:0], 32'd0} + {1'b0, part_reg};
    end

    always_comb
    begin
        st_next   = st_reg;
        tmin_next = tmin_reg;
        tmax_next = tmax_reg;
        vol_next  = vol_reg;
        part_next = part_reg;
        in_ready  = (st_reg == ST_IDLE);
        out_valid = (st_reg == ST_PUSH);
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next   = ST_AX0;
                    tmin_next = '0;
                    tmax_next = $signed(T_FAR);
                end
            end
            ST_AX0, ST_AX1, ST_AX2:
            begin
                if (ta > tmin_reg) tmin_next = ta;
                if (tb < tmax_reg) tmax_next = tb;
                if (st_reg == ST_AX0) st_next = ST_AX1;
                else if (st_reg == ST_AX1) st_next = ST_AX2;
                else
                begin
                    st_next  = ST_VOL1;
                    vol_next = {32'd0, ext_reg[0][31:0]};
                end
            end
            ST_VOL1:
            begin
                // both factors below 2^32, product fits
                vol_next = vp;
                st_next  = ST_VOL2;
            end
            ST_VOL2:
            begin
                part_next = vp;
                st_next   = ST_VOL3;
            end
            ST_VOL3:
            begin
                // high half times extent shifted up, plus the low partial product
                if (vp[63:32] != '0 || vsum[64])
                    vol_next = '1;
                else
                    vol_next = vsum[63:0];
                st_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_ready) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= ST_IDLE;
        else        st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]  <= box_lo[i];
                hi_reg[i]  <= box_hi[i];
                ext_reg[i] <= (box_hi[i] > box_lo[i])
                    ? 33'({box_hi[i][COORD_W-1], box_hi[i]}
                          - {box_lo[i][COORD_W-1], box_lo[i]}) : '0;
            end
            id_reg   <= id_in;
            last_reg <= last_in;
        end
        tmin_reg <= tmin_next;
        tmax_reg <= tmax_next;
        vol_reg  <= vol_next;
        part_reg <= part_next;
    end

    always_comb
    begin
        out_data.hit    = (tmax_reg >= tmin_reg);
        out_data.tmin   = tmin_reg;
        out_data.vol    = vol_reg;
        out_data.id     = 32'(id_reg & 16'(({ID_BITS{1'b1}}) & 32'hFFFF));
        out_data.last   = last_reg;
        out_data.prefer = prefer;
    end
endmodule

// File: src/rbps_back.sv
// back: two-entry queue and best-hit selection across the scan
`timescale 1ns / 1ps
module rbps_back
    import rbps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  box_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit_found,
    output logic [15:0] hit_object
);
    box_result_t q_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic [T_W-1:0]   bd_reg;
    logic [VOL_W-1:0] bv_reg;
    logic [31:0]      bid_reg;
    logic             any_reg;
    logic             ov_reg, of_reg;
    logic [15:0]      oo_reg;
    box_result_t      h;
    logic             pop, push, win;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign h        = q_reg[rp_reg];
    assign pop      = (cnt_reg != 2'd0) && (!ov_reg || out_ready);

    always_comb
    begin
        if (!any_reg)      win = 1'b1;
        else if (h.prefer) win = h.vol < bv_reg;
        else               win = h.tmin < bd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= in_data;
        if (pop && h.hit && win)
        begin
            bd_reg  <= h.tmin;
            bv_reg  <= h.vol;
            bid_reg <= h.id;
        end
        if (pop && h.last)
        begin
            of_reg <= any_reg || h.hit;
            oo_reg <= (h.hit && win) ? h.id[15:0] : (any_reg ? bid_reg[15:0] : 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
            any_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
            begin
                if (h.last) any_reg <= 1'b0;
                else if (h.hit) any_reg <= 1'b1;
            end
            if (pop && h.last) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    assign out_valid  = ov_reg;
    assign hit_found  = of_reg;
    assign hit_object = oo_reg;
endmodule

// File: tb/tb_ray_box_pick_selector.sv
// self-checking testbench for the ray box pick selector: slab test, best-hit pick, result stream
`timescale 1ns / 1ps
module tb_ray_box_pick_selector;
    import rbps_pkg::*;

    localparam longint signed   DIST_FAR = 64'sh7fff_ffff_ffff_ffff;
    localparam longint unsigned VOL_MAX  = 64'hffff_ffff_ffff_ffff;
    localparam int              UNIT     = 1 << 16;

    typedef struct packed {
        logic [2:0][31:0] mx;
        logic [2:0][31:0] mn;
    } box_t;

    typedef struct {
        bit        hit_found;
        bit [15:0] hit_object;
    } pick_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;  // box_min_x,y,z, box_max_x,y,z, object_id
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;  // hit_found, hit_object
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    // copy of the configuration and scan state
    bit [31:0]       ray_org [3];
    bit [17:0]       ray_dir [3];
    bit              vol_mode;
    longint unsigned best_dist;
    longint unsigned best_vol;
    bit [15:0]       best_obj;
    bit              scan_hit;

    pick_t picks_pending [$];
    int    err_count;
    bit    idle_en;
    bit    hold_rx;

    ray_box_pick_selector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint signed slab_dist(longint signed diff, longint unsigned imag,
                                                bit ineg);
        logic [127:0]    prod;
        longint unsigned dmag;
        bit              dneg;
        dneg = diff < 0;
        dmag = dneg ? longint'(-diff) : longint'(diff);
        prod = 128'(dmag) * 128'(imag);
        if (prod > 128'(DIST_FAR))
            prod = 128'(DIST_FAR);
        return (dneg != ineg) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic void clear_scan();
        best_dist = VOL_MAX;
        best_vol  = VOL_MAX;
        best_obj  = '0;
        scan_hit  = 1'b0;
    endfunction

    function automatic void predict_pick(box_t b, bit [15:0] obj, bit last);
        longint signed   tmin, tmax, lo, hi, org_v, dir_v, t0, t1, tmp;
        longint unsigned imag, amag;
        logic [127:0]    vol;
        bit              ineg, hit, win;
        pick_t           p;
        tmin = 0;
        tmax = DIST_FAR;
        vol  = 1;
        hit  = 1'b1;
        for (int ax = 0; ax < 3; ax++)
        begin
            lo    = longint'($signed(b.mn[ax]));
            hi    = longint'($signed(b.mx[ax]));
            org_v = longint'($signed(ray_org[ax]));
            dir_v = longint'($signed(ray_dir[ax]));
            // zero component takes the reciprocal of one positive lsb
            if (dir_v == 0)
            begin
                imag = 64'd1 << 32;
                ineg = 1'b0;
            end
            else
            begin
                amag = (dir_v < 0) ? -dir_v : dir_v;
                imag = (64'd1 << 32) / amag;
                ineg = dir_v < 0;
            end
            t0 = slab_dist(lo - org_v, imag, ineg);
            t1 = slab_dist(hi - org_v, imag, ineg);
            if (ineg)
            begin
                tmp = t0;
                t0  = t1;
                t1  = tmp;
            end
            if (t0 > tmin)
                tmin = t0;
            if (t1 < tmax)
                tmax = t1;
            if (tmax < tmin)
                hit = 1'b0;
            vol = vol * ((hi > lo) ? 128'(hi - lo) : 128'd0);
            if (vol > 128'(VOL_MAX))
                vol = 128'(VOL_MAX);
        end
        if (hit)
        begin
            if (!scan_hit)
                win = 1'b1;
            else if (vol_mode)
                win = vol[63:0] < best_vol;
            else
                win = longint'(tmin) < best_dist;
            if (win)
            begin
                best_dist = tmin;
                best_vol  = vol[63:0];
                best_obj  = obj;
            end
            scan_hit = 1'b1;
        end
        if (last)
        begin
            p.hit_found  = scan_hit;
            p.hit_object = scan_hit ? best_obj : 16'd0;
            picks_pending.insert(picks_pending.size(), p);
            clear_scan();
        end
    endfunction

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("error at %0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
        err_count++;
    endtask

    // box transfers feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_pick(s_axis_tdata[191:0], s_axis_tdata[207:192], s_axis_tlast);
    end

    always @(posedge clk)
    begin
        pick_t p;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (picks_pending.size() == 0)
                report_mismatch("unexpected result", 0, m_axis_tdata);
            else
            begin
                p = picks_pending.pop_front();
                if (m_axis_tdata[0] !== p.hit_found)
                    report_mismatch("hit_found", p.hit_found, m_axis_tdata[0]);
                if (m_axis_tdata[16:1] !== p.hit_object)
                    report_mismatch("hit_object", p.hit_object, m_axis_tdata[16:1]);
            end
        end
    end

    // result side: random stall bursts while idle_en is set, or a long hold while hold_rx is set
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                m_axis_tready <= 1'b0;
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (picks_pending.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ORIGIN_X: ray_org[0] = val;
            REG_ORIGIN_Y: ray_org[1] = val;
            REG_ORIGIN_Z: ray_org[2] = val;
            REG_DIR_X:    ray_dir[0] = val[17:0];
            REG_DIR_Y:    ray_dir[1] = val[17:0];
            REG_DIR_Z:    ray_dir[2] = val[17:0];
            REG_PREFER:   vol_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, bit pref);
        wait_idle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_PREFER, pref);
    endtask

    task automatic send_box(box_t b, bit [15:0] obj, bit last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {obj, b};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic park_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.mn = {z0, y0, x0};
        b.mx = {z1, y1, x1};
        return b;
    endfunction

    function automatic box_t rand_box();
        box_t b;
        int   c, h;
        for (int ax = 0; ax < 3; ax++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                b.mn[ax] = $urandom;
                b.mx[ax] = $urandom;
            end
            else
            begin
                c = $urandom_range(0, 16 * UNIT) - 8 * UNIT;
                h = $urandom_range(0, 3 * UNIT);
                b.mn[ax] = c - h;
                b.mx[ax] = c + h;
            end
        end
        return b;
    endfunction

    function automatic int rand_dir();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return $urandom;
            2:       return ($urandom_range(0, 1) != 0) ? UNIT : -UNIT;
            default: return $urandom_range(0, 2 * UNIT) - UNIT;
        endcase
    endfunction

    task automatic rand_ray();
        set_ray($urandom_range(0, 8 * UNIT) - 4 * UNIT, $urandom_range(0, 8 * UNIT) - 4 * UNIT,
                ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 8 * UNIT) - 4 * UNIT,
                rand_dir(), rand_dir(), rand_dir(), $urandom_range(0, 1));
    endtask

    task automatic rand_scans(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                park_sender();
                rand_ray();
            end
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_box(rand_box(), $urandom, i == len - 1);
            sent += len;
        end
        park_sender();
    endtask

    // default ray: origin 0 looking down -y
    task automatic test_default_ray();
        send_box(make_box(-UNIT, -5 * UNIT, -UNIT, UNIT, -3 * UNIT, UNIT), 16'h0011, 1'b0);
        send_box(make_box(-UNIT, 3 * UNIT, -UNIT, UNIT, 5 * UNIT, UNIT), 16'h00ff, 1'b0);
        send_box(make_box(-UNIT, -9 * UNIT, -UNIT, UNIT, -2 * UNIT, UNIT), 16'hff22, 1'b1);
        // nothing hit: behind the origin and off to the side
        send_box(make_box(-UNIT, 3 * UNIT, -UNIT, UNIT, 5 * UNIT, UNIT), 16'h0033, 1'b0);
        send_box(make_box(2 * UNIT, -5 * UNIT, -UNIT, 3 * UNIT, -3 * UNIT, UNIT), 16'h0044, 1'b1);
        park_sender();
    endtask

    task automatic test_extremes();
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 16'hffff, 1'b0);
        send_box(make_box(0, 0, 0, 0, 0, 0), 16'h0000, 1'b1);
        // inverted box on x, plus an origin-containing box
        send_box(make_box(UNIT, -4 * UNIT, -UNIT, -UNIT, -2 * UNIT, UNIT), 16'h00a5, 1'b0);
        send_box(make_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT), 16'h005a, 1'b1);
        park_sender();
    endtask

    task automatic test_modes();
        set_ray(UNIT / 2, 0, 0, 0, 0, UNIT, 1'b1);
        send_box(make_box(-UNIT, -UNIT, 2 * UNIT, 2 * UNIT, UNIT, 4 * UNIT), 16'h0001, 1'b0);
        send_box(make_box(0, -UNIT, 6 * UNIT, UNIT, UNIT, 7 * UNIT), 16'h0002, 1'b0);
        send_box(make_box(0, -UNIT, 6 * UNIT, UNIT, UNIT, 7 * UNIT), 16'h0003, 1'b1);
        // switch mode in the middle of a scan
        send_box(make_box(-UNIT, -UNIT, 6 * UNIT, 2 * UNIT, UNIT, 9 * UNIT), 16'h0004, 1'b0);
        park_sender();
        wait_idle();
        write_reg(REG_PREFER, 32'd0);
        send_box(make_box(0, -UNIT, 2 * UNIT, UNIT, UNIT, 3 * UNIT), 16'h0005, 1'b1);
        park_sender();
        // an out-of-range x direction, the largest y direction and an ignored register index
        set_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h0002_0000, 32'h0001_ffff, 1, 1'b0);
        write_reg(3'd7, 32'hffff_ffff);
        send_box(make_box(32'h8000_0000, 32'h7000_0000, -UNIT, 32'h7fff_ffff, 32'h7fff_ffff,
                          UNIT), 16'h0077, 1'b1);
        send_box(make_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT), 16'h0088, 1'b1);
        park_sender();
        set_ray(0, 0, 0, -UNIT, 0, UNIT, 1'b1);
        send_box(make_box(-5 * UNIT, -UNIT, UNIT, -UNIT, UNIT, 5 * UNIT), 16'h0099, 1'b1);
        park_sender();
    endtask

    task automatic test_random();
        rand_scans(1000);
    endtask

    task automatic test_backpressure();
        fork
            rand_scans(60);
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
        join
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        rand_scans(120);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        err_count     = 0;
        idle_en       = 1'b1;
        hold_rx       = 1'b0;
        ray_org       = '{0, 0, 0};
        ray_dir       = '{18'd0, 18'h3_0000, 18'd0};
        vol_mode      = 1'b0;
        clear_scan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_ray();
        test_extremes();
        test_modes();
        test_random();
        test_backpressure();
        test_no_idle();

        while (picks_pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("ray_box_pick_selector: match");
        else
            $display("ray_box_pick_selector: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("ray_box_pick_selector: mismatch");
        $finish;
    end

endmodule
